### hdl/piea_pkg.sv
// Package for the positional insert/erase array.
// Holds field widths, operation codes and the per-cell action struct.
// No dependencies.
`default_nettype none
package piea_pkg;
	localparam int OP_W         = 3;
	localparam int POS_W        = 6;
	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 64;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
	localparam logic [OP_W-1:0] OP_READ   = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	typedef struct packed {
		logic shift_up;
		logic fill;
		logic shift_down;
		logic write;
	} act_t;
endpackage
`default_nettype wire

### hdl/piea_cell.sv
// One element slot of the array chain.
// Takes its new contents from the broadcast value, a neighbour or zero.
// Depends on piea_pkg.
`default_nettype none
module piea_cell #(
	parameter int IDX   = 0,
	parameter int CMP_W = 8
) (
	input  wire                              clk,
	input  wire                              en,
	input  wire piea_pkg::act_t              act,
	input  wire  [CMP_W-1:0]                 pos,
	input  wire  [CMP_W-1:0]                 cnt,
	input  wire  [piea_pkg::DATA_W-1:0]      value,
	input  wire  [piea_pkg::DATA_W-1:0]      prev_data,
	input  wire  [piea_pkg::DATA_W-1:0]      next_data,
	output logic [piea_pkg::DATA_W-1:0]      data_q
);
	localparam logic [CMP_W-1:0] IDX_C  = CMP_W'(IDX);
	localparam logic [CMP_W-1:0] IDX1_C = CMP_W'(IDX + 1);

	logic                        hit;
	logic                        load;
	logic [piea_pkg::DATA_W-1:0] data_d;

	assign hit = (IDX_C == pos);

	always_comb begin
		load   = 1'b0;
		data_d = data_q;
		priority if ((act.shift_up || act.fill || act.write) && hit) begin
			load   = 1'b1;
			data_d = value;
		end else if (act.shift_up && IDX_C > pos && IDX_C <= cnt) begin
			load   = 1'b1;
			data_d = prev_data;
		end else if (act.fill && IDX_C >= cnt && IDX_C < pos) begin
			load   = 1'b1;
			data_d = '0;
		end else if (act.shift_down && IDX_C >= pos && IDX1_C < cnt) begin
			load   = 1'b1;
			data_d = next_data;
		end
	end

	always_ff @(posedge clk) begin
		if (en && load) begin
			data_q <= data_d;
		end
	end
endmodule
`default_nettype wire

### hdl/positional_insert_erase_array.sv
// Positional insert/erase array: a chain of CAPACITY element cells and a count.
// The result is registered and appears in the cycle after the input transfer; throughput one operation
// per cycle while out_ready does not stall the output, set by the parallel shift of all cells.
// A result held in the output register does not block the next input while it is taken.
// Reset (arst_n low) clears the count and the output valid; element contents are undefined.
// Depends on piea_pkg and piea_cell.
`default_nettype none
module positional_insert_erase_array #(
	parameter int CAPACITY = piea_pkg::CAPACITY_DEF,
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [piea_pkg::OP_W-1:0]           opcode,
	input  wire  [piea_pkg::POS_W-1:0]          position,
	input  wire  signed [piea_pkg::DATA_W-1:0]  value,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic                                ok,
	output logic signed [piea_pkg::DATA_W-1:0]  read_value,
	output logic [CW-1:0]                       count
);
	localparam int CMP_W = ((CW > piea_pkg::POS_W) ? CW : piea_pkg::POS_W) + 1;
	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

	logic                        accept;
	logic [CW-1:0]               cnt_q;
	logic [CMP_W-1:0]            pos_c;
	logic [CMP_W-1:0]            cnt_c;
	logic                        in_range;
	piea_pkg::act_t              act;
	logic                        ok_d;
	logic [CMP_W-1:0]            cnt_d;
	logic [piea_pkg::DATA_W-1:0] rd_sel;
	logic [piea_pkg::DATA_W-1:0] cell_data [CAPACITY];
	logic [piea_pkg::DATA_W-1:0] prev_d    [CAPACITY];
	logic [piea_pkg::DATA_W-1:0] next_d    [CAPACITY];

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;
	assign pos_c    = CMP_W'(position);
	assign cnt_c    = CMP_W'(cnt_q);
	assign in_range = (pos_c < cnt_c);

	always_comb begin
		act   = '0;
		ok_d  = 1'b0;
		cnt_d = cnt_c;
		unique case (opcode)
			piea_pkg::OP_INSERT: begin
				if (cnt_c < CAP_C && pos_c < CAP_C) begin
					ok_d = 1'b1;
					if (in_range) begin
						act.shift_up = 1'b1;
						cnt_d        = cnt_c + CMP_W'(1);
					end else begin
						act.fill = 1'b1;
						cnt_d    = pos_c + CMP_W'(1);
					end
				end
			end
			piea_pkg::OP_ERASE: begin
				if (in_range) begin
					ok_d           = 1'b1;
					act.shift_down = 1'b1;
					cnt_d          = cnt_c - CMP_W'(1);
				end
			end
			piea_pkg::OP_READ: begin
				ok_d = in_range;
			end
			piea_pkg::OP_WRITE: begin
				ok_d      = in_range;
				act.write = in_range;
			end
			piea_pkg::OP_CLEAR: begin
				ok_d  = 1'b1;
				cnt_d = '0;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CMP_W'(i) == pos_c) begin
				rd_sel = rd_sel | cell_data[i];
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_d[i] = '0;
		end else begin : g_prev
			assign prev_d[i] = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_d[i] = '0;
		end else begin : g_next
			assign next_d[i] = cell_data[i+1];
		end

		piea_cell #(
			.IDX   (i),
			.CMP_W (CMP_W)
		) u_cell (
			.clk       (clk),
			.en        (accept),
			.act       (act),
			.pos       (pos_c),
			.cnt       (cnt_c),
			.value     (value),
			.prev_data (prev_d[i]),
			.next_data (next_d[i]),
			.data_q    (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q     <= cnt_d[CW-1:0];
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok         <= ok_d;
			read_value <= (opcode == piea_pkg::OP_READ && in_range) ? rd_sel : '0;
			count      <= cnt_d[CW-1:0];
		end
	end
endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the positional insert/erase array, with a queue-fed driver,
// a checking monitor and a built-in prediction of the array contents and element count.
// Depends on piea_pkg and positional_insert_erase_array.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP      = piea_pkg::CAPACITY_DEF;
	localparam int CNT_W    = $clog2(CAP + 1);
	localparam int N_RANDOM = 2000;
	localparam int PHASE_LEN = 150;

	typedef struct packed {
		logic [piea_pkg::OP_W-1:0]          op;
		logic [piea_pkg::POS_W-1:0]         pos;
		logic signed [piea_pkg::DATA_W-1:0] val;
	} array_op_t;

	typedef struct packed {
		logic                               ok;
		logic signed [piea_pkg::DATA_W-1:0] rd;
		logic [CNT_W-1:0]                   cnt;
	} array_res_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [piea_pkg::OP_W-1:0]          opcode = '0;
	logic [piea_pkg::POS_W-1:0]         position = '0;
	logic signed [piea_pkg::DATA_W-1:0] value = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic                               ok;
	logic signed [piea_pkg::DATA_W-1:0] read_value;
	logic [CNT_W-1:0]                   count;

	array_op_t  pending_ops[$];
	array_res_t expected_results[$];
	logic       in_taken = 1'b0;

	logic [piea_pkg::DATA_W-1:0] shadow_mem[CAP];
	int                          shadow_len = 0;
	int                          gen_len = 0;
	int                          ops_accepted = 0;
	int                          results_checked = 0;
	int                          error_cnt = 0;
	int                          rejected_cnt = 0;
	int                          full_refusals = 0;
	int                          peak_len = 0;

	positional_insert_erase_array u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.read_value (read_value),
		.count      (count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int traffic_phase();
		return (ops_accepted / PHASE_LEN) % 4;
	endfunction

	task automatic apply_array_op(input array_op_t it, output array_res_t r);
		int i;
		int p;
		r = '0;
		p = it.pos;
		case (it.op)
			piea_pkg::OP_INSERT: begin
				if (shadow_len < CAP && p < CAP) begin
					if (p < shadow_len) begin
						for (i = shadow_len; i > p; i--)
							shadow_mem[i] = shadow_mem[i-1];
						shadow_len++;
					end else begin
						for (i = shadow_len; i < p; i++)
							shadow_mem[i] = '0;
						shadow_len = p + 1;
					end
					shadow_mem[p] = it.val;
					r.ok = 1'b1;
				end else if (shadow_len >= CAP) begin
					full_refusals++;
				end
			end
			piea_pkg::OP_ERASE: begin
				if (p < shadow_len) begin
					for (i = p; i + 1 < shadow_len; i++)
						shadow_mem[i] = shadow_mem[i+1];
					shadow_len--;
					r.ok = 1'b1;
				end
			end
			piea_pkg::OP_READ: begin
				if (p < shadow_len) begin
					r.rd = shadow_mem[p];
					r.ok = 1'b1;
				end
			end
			piea_pkg::OP_WRITE: begin
				if (p < shadow_len) begin
					shadow_mem[p] = it.val;
					r.ok = 1'b1;
				end
			end
			piea_pkg::OP_CLEAR: begin
				shadow_len = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		if (!r.ok)
			rejected_cnt++;
		if (shadow_len > peak_len)
			peak_len = shadow_len;
		r.cnt = shadow_len[CNT_W-1:0];
	endtask

	task automatic push_op(input logic [piea_pkg::OP_W-1:0] op, input int pos,
		input logic [piea_pkg::DATA_W-1:0] val);
		array_op_t it;
		it.op  = op;
		it.pos = pos[piea_pkg::POS_W-1:0];
		it.val = val;
		pending_ops.push_back(it);
		case (op)
			piea_pkg::OP_INSERT:
				if (gen_len < CAP) gen_len = (pos < gen_len) ? gen_len + 1 : pos + 1;
			piea_pkg::OP_ERASE:  if (pos < gen_len) gen_len--;
			piea_pkg::OP_CLEAR:  gen_len = 0;
			default: ;
		endcase
	endtask

	always @(negedge clk) begin
		int  ph;
		bit  hold;
		array_op_t it;
		if (arst_n && (!in_valid || in_taken)) begin
			ph = traffic_phase();
			hold = (ph == 1 && $urandom_range(0, 99) < 49) ||
				(ph == 3 && $urandom_range(0, 99) < 11);
			if (pending_ops.size() != 0 && !hold) begin
				it = pending_ops.pop_front();
				in_valid <= 1'b1;
				opcode   <= it.op;
				position <= it.pos;
				value    <= it.val;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		int ph;
		if (arst_n) begin
			ph = traffic_phase();
			out_ready <= !((ph == 2 && $urandom_range(0, 99) < 49) ||
				(ph == 3 && $urandom_range(0, 99) < 11));
		end
	end

	always @(posedge clk) begin
		array_res_t exp_r;
		array_op_t  it;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result ok=%0b read_value=%0d count=%0d",
						$time, ok, read_value, count);
					error_cnt++;
				end else begin
					exp_r = expected_results.pop_front();
					results_checked++;
					if (ok !== exp_r.ok) begin
						$display("%0t: ok mismatch, expected %0b, actual %0b",
							$time, exp_r.ok, ok);
						error_cnt++;
					end
					if (read_value !== exp_r.rd) begin
						$display("%0t: read_value mismatch, expected %0d, actual %0d",
							$time, exp_r.rd, read_value);
						error_cnt++;
					end
					if (count !== exp_r.cnt) begin
						$display("%0t: count mismatch, expected %0d, actual %0d",
							$time, exp_r.cnt, count);
						error_cnt++;
					end
				end
			end
			if (in_valid && in_ready) begin
				it.op  = opcode;
				it.pos = position;
				it.val = value;
				apply_array_op(it, exp_r);
				expected_results.push_back(exp_r);
				ops_accepted <= ops_accepted + 1;
			end
			in_taken <= in_valid && in_ready;
		end
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d results outstanding", expected_results.size());
		$display("FAIL positional_insert_erase_array");
		$finish;
	end

	initial begin
		int n;
		int r;
		int pos;
		bit grow;
		logic [piea_pkg::OP_W-1:0]   op;
		logic [piea_pkg::DATA_W-1:0] val;

		// Directed part: empty-array rejects, shifts, gap fill, full array and clear.
		push_op(piea_pkg::OP_READ,   0,  32'h0);
		push_op(piea_pkg::OP_ERASE,  0,  32'h0);
		push_op(piea_pkg::OP_WRITE,  0,  32'h1);
		push_op(piea_pkg::OP_INSERT, 0,  32'h7fffffff);
		push_op(piea_pkg::OP_INSERT, 0,  32'h80000000);
		push_op(piea_pkg::OP_INSERT, 5,  32'hffffffff);
		push_op(piea_pkg::OP_READ,   3,  32'h0);
		push_op(piea_pkg::OP_READ,   5,  32'h0);
		push_op(piea_pkg::OP_READ,   6,  32'h0);
		push_op(piea_pkg::OP_INSERT, 1,  32'h12345678);
		push_op(piea_pkg::OP_ERASE,  0,  32'h0);
		push_op(piea_pkg::OP_WRITE,  5,  32'h55aa55aa);
		push_op(piea_pkg::OP_READ,   5,  32'h0);
		push_op(piea_pkg::OP_ERASE,  5,  32'h0);
		push_op(piea_pkg::OP_ERASE,  63, 32'h0);
		push_op(piea_pkg::OP_CLEAR,  0,  32'h0);
		push_op(piea_pkg::OP_READ,   0,  32'h0);
		push_op(piea_pkg::OP_INSERT, 63, 32'hdeadbeef);
		push_op(piea_pkg::OP_READ,   63, 32'h0);
		push_op(piea_pkg::OP_INSERT, 10, 32'h1);
		push_op(piea_pkg::OP_INSERT, 63, 32'h2);
		push_op(piea_pkg::OP_ERASE,  0,  32'h0);
		push_op(piea_pkg::OP_READ,   62, 32'h0);
		push_op(3'd5,                0,  32'hffffffff);
		push_op(3'd7,                63, 32'h0);
		push_op(piea_pkg::OP_INSERT, 0,  32'h0);
		push_op(piea_pkg::OP_CLEAR,  63, 32'hffffffff);
		push_op(piea_pkg::OP_INSERT, 2,  32'h00000003);
		push_op(piea_pkg::OP_READ,   0,  32'h0);

		n = 0;
		while (n < N_RANDOM) begin
			grow = ((n / 250) % 2) == 0;
			r = $urandom_range(0, 99);
			if (r < 2)
				op = piea_pkg::OP_CLEAR;
			else if (r < 4)
				op = piea_pkg::OP_W'($urandom_range(5, 7));
			else if (r < (grow ? 56 : 20))
				op = piea_pkg::OP_INSERT;
			else if (r < (grow ? 66 : 60))
				op = piea_pkg::OP_ERASE;
			else if (r < 82)
				op = piea_pkg::OP_READ;
			else
				op = piea_pkg::OP_WRITE;

			if ($urandom_range(0, 99) < 82) begin
				if (op == piea_pkg::OP_INSERT)
					pos = $urandom_range(0, (gen_len < CAP - 1) ? gen_len : CAP - 1);
				else
					pos = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
			end else begin
				pos = $urandom_range(0, CAP - 1);
			end

			case ($urandom_range(0, 19))
				0:       val = 32'h7fffffff;
				1:       val = 32'h80000000;
				2:       val = 32'h0;
				3:       val = 32'hffffffff;
				default: val = $urandom;
			endcase

			push_op(op, pos, val);
			if (op <= piea_pkg::OP_CLEAR)
				n++;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d operations with %0d results checked; %0d were rejected,",
			ops_accepted, results_checked, rejected_cnt);
		$display("the array peaked at %0d elements and %0d inserts were refused when full.",
			peak_len, full_refusals);
		if (error_cnt == 0 && expected_results.size() == 0) begin
			$display("PASS positional_insert_erase_array");
		end else begin
			$display("FAIL positional_insert_erase_array");
		end
		$finish;
	end
endmodule
